// File: hdl/vfs_pkg.sv
// ----------------------------------------------------------------------------
// vfs_pkg
// Shared types and constants of the vertical eight-tap scaler: register
// indexes, reset values, the kernel arithmetic constants and the tag that
// travels with each result.
// ----------------------------------------------------------------------------
package vfs_pkg;

  // Number of kernel taps, which is also the number of rows in the line store.
  localparam int TAPS          = 8;
  localparam int BANK_W        = 3;

  // Default line store width in pixels.
  localparam int MAX_WIDTH_DEF = 2048;

  // Field widths.
  localparam int PIX_W         = 8;
  localparam int ROW_W         = 16;
  localparam int OUT_COL_W     = 11;
  localparam int LEN_W         = 12;
  localparam int TAPS_REG_W    = 64;
  localparam int CFG_INDEX_W   = 3;
  localparam int CFG_DATA_W    = 64;

  // Result arithmetic: round by adding half an LSB, then drop the fraction.
  localparam int ROUND_BIAS    = 16;
  localparam int FRAC_BITS     = 5;
  localparam int PIX_MAX       = 255;

  // Width of a running count of results caused by one item (at most five).
  localparam int CNT_W         = 3;

  // Register reset values.
  localparam logic [TAPS_REG_W-1:0] KERNEL_TAPS_RST = 64'hFFFF_030F_0F03_FFFF;
  localparam logic [LEN_W-1:0]      ROW_LENGTH_RST  = 12'd2048;
  localparam logic [ROW_W-1:0]      ROW_COUNT_RST   = 16'd1;
  localparam logic                  HALF_MODE_RST   = 1'b1;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_KERNEL_TAPS = 3'd0,
    REG_ROW_LENGTH  = 3'd1,
    REG_ROW_COUNT   = 3'd2,
    REG_HALF_MODE   = 3'd3
  } vfs_reg_e;

  typedef logic [PIX_W-1:0]           vfs_pix_t;
  typedef logic [TAPS-1:0][PIX_W-1:0] vfs_row_set_t;

  // Position and framing of one result.
  typedef struct packed {
    logic [ROW_W-1:0]     out_row;
    logic [OUT_COL_W-1:0] out_col;
    logic                 last;
  } vfs_tag_t;

endpackage

// File: hdl/vfs_line_store.sv
// ----------------------------------------------------------------------------
// vfs_line_store
// Eight row banks of pixel memory. Source row r lives in bank r mod 8. One
// bank is written per cycle and all banks are read at the same column, with
// registered read data.
// ----------------------------------------------------------------------------
module vfs_line_store #(
  parameter int MAX_WIDTH = vfs_pkg::MAX_WIDTH_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   wr_en_i,
  input  logic [vfs_pkg::BANK_W-1:0]             wr_bank_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]           addr_i,
  input  vfs_pkg::vfs_pix_t                      wr_data_i,
  input  logic                                   rd_en_i,
  output vfs_pkg::vfs_row_set_t                  rd_data_o
);

  localparam int COL_W = $clog2(MAX_WIDTH);

  for (genvar b = 0; b < vfs_pkg::TAPS; b++) begin : g_bank
    logic [vfs_pkg::PIX_W-1:0] mem [MAX_WIDTH];
    logic [vfs_pkg::PIX_W-1:0] rd_q;

    // One write port and one registered read port per bank.
    always_ff @(posedge clk_i) begin
      if (wr_en_i && (wr_bank_i == vfs_pkg::BANK_W'(b))) begin
        mem[addr_i[COL_W-1:0]] <= wr_data_i;
      end
      if (rd_en_i) begin
        rd_q <= mem[addr_i[COL_W-1:0]];
      end
    end

    assign rd_data_o[b] = rd_q;
  end

endmodule

// File: hdl/vfs_kernel.sv
// ----------------------------------------------------------------------------
// vfs_kernel
// Eight-tap multiply and accumulate with rounding and clamping. A product
// register and a result register form two stages with their own valid bits.
// ----------------------------------------------------------------------------
module vfs_kernel (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [vfs_pkg::TAPS_REG_W-1:0]    taps_i,
  input  vfs_pkg::vfs_row_set_t             pix_i,
  input  vfs_pkg::vfs_tag_t                 tag_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output vfs_pkg::vfs_pix_t                 value_o,
  output vfs_pkg::vfs_tag_t                 tag_o
);

  localparam int PROD_W = 2 * vfs_pkg::PIX_W;
  localparam int SUM_W  = PROD_W + $clog2(vfs_pkg::TAPS);

  logic                     p_valid_q;
  logic signed [PROD_W-1:0] prod_d [vfs_pkg::TAPS];
  logic signed [PROD_W-1:0] prod_q [vfs_pkg::TAPS];
  vfs_pkg::vfs_tag_t        p_tag_q;
  logic                     p_ready;

  logic                     o_valid_q;
  vfs_pkg::vfs_pix_t        o_value_q;
  vfs_pkg::vfs_pix_t        o_value_d;
  vfs_pkg::vfs_tag_t        o_tag_q;
  logic                     o_ready;

  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  scaled;

  // Each stage takes a new item when empty or when it hands its item on.
  assign o_ready    = !o_valid_q || out_ready_i;
  assign p_ready    = !p_valid_q || o_ready;
  assign in_ready_o = p_ready;

  // Signed tap times unsigned pixel; the product fits in sixteen bits.
  always_comb begin
    for (int i = 0; i < vfs_pkg::TAPS; i++) begin
      prod_d[i] = PROD_W'($signed(taps_i[vfs_pkg::PIX_W*i +: vfs_pkg::PIX_W]) *
                          $signed({1'b0, pix_i[i]}));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
    end else if (p_ready) begin
      p_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_ready && in_valid_i) begin
      for (int i = 0; i < vfs_pkg::TAPS; i++) begin
        prod_q[i] <= prod_d[i];
      end
      p_tag_q <= tag_i;
    end
  end

  // Sum the products, round, and clamp to the pixel range.
  always_comb begin
    sum = SUM_W'(vfs_pkg::ROUND_BIAS);
    for (int i = 0; i < vfs_pkg::TAPS; i++) begin
      sum = sum + SUM_W'(prod_q[i]);
    end
    scaled = sum >>> vfs_pkg::FRAC_BITS;
    if (sum < 0) begin
      o_value_d = '0;
    end else if (scaled > SUM_W'(vfs_pkg::PIX_MAX)) begin
      o_value_d = vfs_pkg::PIX_W'(vfs_pkg::PIX_MAX);
    end else begin
      o_value_d = scaled[vfs_pkg::PIX_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else if (o_ready) begin
      o_valid_q <= p_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (o_ready && p_valid_q) begin
      o_value_q <= o_value_d;
      o_tag_q   <= p_tag_q;
    end
  end

  assign out_valid_o = o_valid_q;
  assign value_o     = o_value_q;
  assign tag_o       = o_tag_q;

endmodule

// File: hdl/vertical_fir8_scaler.sv
// ----------------------------------------------------------------------------
// vertical_fir8_scaler
// Vertical eight-tap filter over a raster pixel stream, with an optional
// halving of the row count. The last eight source rows are kept in banked
// line memory; rows outside the frame repeat the nearest edge row.
// ----------------------------------------------------------------------------
// Path: an item's first result passes the line store read and sequencer registers,
// then the product and result registers. Throughput: one item per cycle while each
// item causes at most one result and the output is not stalled; an item causing n
// results holds the input until its last result issues, one per cycle unless stalled.
// Reset: position, valid bits and registers return to defaults at once; the
// line store is not cleared and is only read where it has been written.
// ----------------------------------------------------------------------------
module vertical_fir8_scaler #(
  parameter int MAX_WIDTH = vfs_pkg::MAX_WIDTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration write port.
  input  logic                               cfg_we_i,
  input  logic [vfs_pkg::CFG_INDEX_W-1:0]    cfg_index_i,
  input  logic [vfs_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  // Source pixels.
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [7:0]                         s_axis_tdata,   // [7:0] pixel
  // Filtered pixels.
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [39:0]                        m_axis_tdata,   // [7:0] value,
                                                             // [23:8] out_row,
                                                             // [34:24] out_col
  output logic                               m_axis_tlast    // last_of_run
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = vfs_pkg::ROW_W;
  localparam int CNT_W  = vfs_pkg::CNT_W;
  localparam int TAPS   = vfs_pkg::TAPS;
  localparam int BANK_W = vfs_pkg::BANK_W;

  // Configuration registers.
  logic [vfs_pkg::TAPS_REG_W-1:0] kernel_taps_q;
  logic [vfs_pkg::LEN_W-1:0]      row_length_q;
  logic [ROW_W-1:0]               row_count_q;
  logic                           half_mode_q;
  logic                           geom_write;

  // Source position.
  logic [COL_W-1:0] src_col_q, src_col_d;
  logic [ROW_W-1:0] src_row_q, src_row_d;
  logic [COL_W-1:0] col_last;
  logic [ROW_W-1:0] row_last;
  logic             in_fire;

  // Results caused by the incoming item.
  logic             is_last_row;
  logic [ROW_W-1:0] half_row;
  logic [ROW_W-1:0] y_first_d;
  logic [CNT_W-1:0] cnt_d;

  // Sequencer stage behind the line store read.
  logic                  a_valid_q;
  vfs_pkg::vfs_pix_t     a_pix_q;
  logic [ROW_W-1:0]      a_row_q;
  logic [COL_W-1:0]      a_col_q;
  logic [ROW_W-1:0]      a_y_first_q;
  logic [CNT_W-1:0]      a_cnt_q;
  logic [CNT_W-1:0]      a_k_q;
  logic                  a_at_end;
  logic                  a_ready;
  logic                  k_ready;

  vfs_pkg::vfs_row_set_t rd_data;
  vfs_pkg::vfs_row_set_t row_val;
  vfs_pkg::vfs_row_set_t tap_pix;
  vfs_pkg::vfs_tag_t     k_tag;
  logic [ROW_W-1:0]      cur_y;
  logic [ROW_W:0]        base;
  logic signed [ROW_W+1:0] trow;
  logic [BANK_W-1:0]     bank;

  vfs_pkg::vfs_pix_t     out_value;
  vfs_pkg::vfs_tag_t     out_tag;

  assign geom_write = cfg_we_i &&
                      ((cfg_index_i == vfs_pkg::REG_ROW_LENGTH) ||
                       (cfg_index_i == vfs_pkg::REG_ROW_COUNT)  ||
                       (cfg_index_i == vfs_pkg::REG_HALF_MODE));

  // Register writes; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kernel_taps_q <= vfs_pkg::KERNEL_TAPS_RST;
      row_length_q  <= vfs_pkg::ROW_LENGTH_RST;
      row_count_q   <= vfs_pkg::ROW_COUNT_RST;
      half_mode_q   <= vfs_pkg::HALF_MODE_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        vfs_pkg::REG_KERNEL_TAPS: kernel_taps_q <= cfg_wdata_i[vfs_pkg::TAPS_REG_W-1:0];
        vfs_pkg::REG_ROW_LENGTH:  row_length_q  <= cfg_wdata_i[vfs_pkg::LEN_W-1:0];
        vfs_pkg::REG_ROW_COUNT:   row_count_q   <= cfg_wdata_i[ROW_W-1:0];
        vfs_pkg::REG_HALF_MODE:   half_mode_q   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Last column and last row; a zero length or count acts as one, a longer row as MAX_WIDTH.
  always_comb begin
    if (row_length_q == '0) begin
      col_last = '0;
    end else if (32'(row_length_q) >= 32'(MAX_WIDTH)) begin
      col_last = COL_W'(MAX_WIDTH - 1);
    end else begin
      col_last = COL_W'(row_length_q - 1'b1);
    end
    row_last = (row_count_q == '0) ? '0 : row_count_q - 1'b1;
  end

  assign in_fire = s_axis_tvalid && s_axis_tready;

  // Raster position of the next pixel, wrapping at the frame end.
  always_comb begin
    src_col_d = src_col_q;
    src_row_d = src_row_q;
    if (in_fire) begin
      if (src_col_q == col_last) begin
        src_col_d = '0;
        src_row_d = (src_row_q == row_last) ? '0 : src_row_q + 1'b1;
      end else begin
        src_col_d = src_col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_col_q <= '0;
      src_row_q <= '0;
    end else if (geom_write) begin
      src_col_q <= '0;
      src_row_q <= '0;
    end else begin
      src_col_q <= src_col_d;
      src_row_q <= src_row_d;
    end
  end

  // Output rows whose last source row is the current one. They are always
  // consecutive; the last source row of the frame can close several at once.
  always_comb begin
    is_last_row = (src_row_q == row_last);
    half_row    = src_row_q >> 1;
    y_first_d   = '0;
    cnt_d       = '0;
    if (half_mode_q) begin
      if (is_last_row) begin
        if (src_row_q[0]) begin
          cnt_d     = (half_row >= 16'd1) ? CNT_W'(2) : CNT_W'(1);
          y_first_d = (half_row >= 16'd1) ? half_row - 16'd1 : '0;
        end else begin
          cnt_d     = (half_row >= 16'd2) ? CNT_W'(3) : CNT_W'(half_row[1:0]) + CNT_W'(1);
          y_first_d = (half_row >= 16'd2) ? half_row - 16'd2 : '0;
        end
      end else if (!src_row_q[0] && (src_row_q >= 16'd4)) begin
        cnt_d     = CNT_W'(1);
        y_first_d = half_row - 16'd2;
      end
    end else begin
      if (is_last_row) begin
        cnt_d     = (src_row_q >= 16'd4) ? CNT_W'(5) : CNT_W'(src_row_q[1:0]) + CNT_W'(1);
        y_first_d = (src_row_q >= 16'd4) ? src_row_q - 16'd4 : '0;
      end else if (src_row_q >= 16'd4) begin
        cnt_d     = CNT_W'(1);
        y_first_d = src_row_q - 16'd4;
      end
    end
  end

  // Line store: write the new pixel and read the other rows of its column.
  vfs_line_store #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_store (
    .clk_i     (clk_i),
    .wr_en_i   (in_fire),
    .wr_bank_i (src_row_q[BANK_W-1:0]),
    .addr_i    (src_col_q),
    .wr_data_i (s_axis_tdata),
    .rd_en_i   (in_fire),
    .rd_data_o (rd_data)
  );

  // The sequencer frees after issuing its last result.
  assign a_at_end      = (a_k_q == a_cnt_q - 1'b1);
  assign a_ready       = !a_valid_q || (k_ready && a_at_end);
  assign s_axis_tready = a_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      a_k_q     <= '0;
    end else if (in_fire) begin
      a_valid_q <= (cnt_d != '0);
      a_k_q     <= '0;
    end else if (a_valid_q && k_ready) begin
      if (a_at_end) begin
        a_valid_q <= 1'b0;
      end else begin
        a_k_q <= a_k_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      a_pix_q     <= s_axis_tdata;
      a_row_q     <= src_row_q;
      a_col_q     <= src_col_q;
      a_y_first_q <= y_first_d;
      a_cnt_q     <= cnt_d;
    end
  end

  // The current row's bank holds stale data for this column; use the pixel.
  always_comb begin
    for (int j = 0; j < TAPS; j++) begin
      row_val[j] = (BANK_W'(j) == a_row_q[BANK_W-1:0]) ? a_pix_q : rd_data[j];
    end
  end

  // Tap i reads row base-3+i, clamped to the frame. The upper clamp can only
  // act on the frame's last row, which is the current one.
  always_comb begin
    cur_y = a_y_first_q + ROW_W'(a_k_q);
    base  = half_mode_q ? {cur_y, 1'b0} : {1'b0, cur_y};
    trow  = '0;
    bank  = '0;
    for (int i = 0; i < TAPS; i++) begin
      trow = $signed({1'b0, base}) - (ROW_W+2)'(3) + (ROW_W+2)'(i);
      if (trow < 0) begin
        bank = '0;
      end else if (trow > $signed({2'b00, a_row_q})) begin
        bank = a_row_q[BANK_W-1:0];
      end else begin
        bank = trow[BANK_W-1:0];
      end
      tap_pix[i] = row_val[bank];
    end
  end

  always_comb begin
    k_tag.out_row = cur_y;
    k_tag.out_col = vfs_pkg::OUT_COL_W'(a_col_q);
    k_tag.last    = a_at_end;
  end

  vfs_kernel u_kernel (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (a_valid_q),
    .in_ready_o  (k_ready),
    .taps_i      (kernel_taps_q),
    .pix_i       (tap_pix),
    .tag_i       (k_tag),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .value_o     (out_value),
    .tag_o       (out_tag)
  );

  assign m_axis_tdata = {5'b00000, out_tag.out_col, out_tag.out_row, out_value};
  assign m_axis_tlast = out_tag.last;

endmodule
